FILE: sv/lpl_pkg.sv
`default_nettype none
package lpl_pkg;

  // fixed-point format of gains and output samples
  localparam int FRAC_BITS    = 18;
  localparam int MAX_CHANNELS = 2;
  localparam int DEF_DEPTH    = 256;

  localparam int SAMPLE_W = 24;
  localparam int GAIN_W   = 19;
  localparam int OUT_W    = 20;

  localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(1 << FRAC_BITS);

  // register reset values
  localparam logic [18:0] CEILING_RST   = 19'd233635;
  localparam logic [7:0]  LOOKAHEAD_RST = 8'd240;
  localparam logic [18:0] RELEASE_RST   = 19'd109;
  localparam logic [1:0]  CHANNELS_RST  = 2'd2;

  // register indexes (word address)
  localparam logic [1:0] REG_CEILING   = 2'd0;
  localparam logic [1:0] REG_LOOKAHEAD = 2'd1;
  localparam logic [1:0] REG_RELEASE   = 2'd2;
  localparam logic [1:0] REG_CHANNELS  = 2'd3;

  // request kinds
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  // classified item handed from front to back
  typedef struct packed {
    logic                kind;
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
    logic [GAIN_W-1:0]   needed;
  } item_t;

endpackage
`default_nettype wire

FILE: sv/lpl_ram.sv
`default_nettype none
module lpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: sv/lpl_front.sv
`default_nettype none
module lpl_front (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [18:0]            ceiling,
  input  wire logic [1:0]             channels_in_use,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic                   in_kind,
  input  wire logic [47:0]            in_data,
  output logic                        q_valid,
  input  wire logic                   q_ready,
  output lpl_pkg::item_t              q_item
);
  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} fstate_t;

  localparam int CNT_W = $clog2(lpl_pkg::FRAC_BITS + 1);
  localparam int TOP_CH = (lpl_pkg::MAX_CHANNELS < 2) ? lpl_pkg::MAX_CHANNELS : 2;

  fstate_t                      state;
  lpl_pkg::item_t               item;
  logic [lpl_pkg::SAMPLE_W:0]   rem;
  logic [lpl_pkg::SAMPLE_W-1:0] peak;
  logic [CNT_W-1:0]             cnt;

  logic [1:0]                   nch;
  logic signed [23:0]           sl, sr;
  logic [23:0]                  mag_l, mag_r, peak_now;
  logic [lpl_pkg::SAMPLE_W+1:0] trial;

  // channel count clamp
  always_comb begin
    nch = channels_in_use;
    if (nch == 2'd0) nch = 2'd1;
    if (nch > 2'(TOP_CH)) nch = 2'(TOP_CH);
  end

  // peak over channels in use
  always_comb begin
    sl = in_data[23:0];
    sr = (nch > 2'd1) ? in_data[47:24] : 24'sd0;
    mag_l = sl[23] ? 24'(-sl) : 24'(sl);
    mag_r = sr[23] ? 24'(-sr) : 24'(sr);
    peak_now = (mag_r > mag_l) ? mag_r : mag_l;
  end

  assign trial    = {rem, 1'b0};
  assign in_ready = (state == F_IDLE);
  assign q_valid  = (state == F_PUSH);
  assign q_item   = item;

  // classify, then one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (in_valid) begin
            item.kind   <= in_kind;
            item.left   <= in_data[23:0];
            item.right  <= (nch > 2'd1) ? in_data[47:24] : 24'd0;
            item.needed <= lpl_pkg::UNITY;
            peak        <= peak_now;
            rem         <= 25'(ceiling);
            cnt         <= '0;
            if (in_kind == lpl_pkg::KIND_FRAME && peak_now > 24'(ceiling)) begin
              state <= F_DIV;
            end else begin
              state <= F_PUSH;
            end
          end
        end
        F_DIV: begin
          if (trial >= 26'(peak)) begin
            rem         <= 25'(trial - 26'(peak));
            item.needed <= {item.needed[lpl_pkg::GAIN_W-2:0], 1'b1};
          end else begin
            rem         <= trial[lpl_pkg::SAMPLE_W:0];
            item.needed <= {item.needed[lpl_pkg::GAIN_W-2:0], 1'b0};
          end
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(lpl_pkg::FRAC_BITS - 1)) state <= F_PUSH;
        end
        F_PUSH: begin
          if (q_ready) state <= F_IDLE;
        end
        default: state <= F_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/lpl_queue.sv
`default_nettype none
module lpl_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_valid,
  output logic                wr_ready,
  input  wire lpl_pkg::item_t wr_item,
  output logic                rd_valid,
  input  wire logic           rd_ready,
  output lpl_pkg::item_t      rd_item
);
  // two-entry queue
  lpl_pkg::item_t slots [2];
  logic           wptr, rptr;
  logic [1:0]     count;
  logic           push, pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_item  = slots[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= wr_item;
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end
endmodule
`default_nettype wire

FILE: sv/lpl_back.sv
`default_nettype none
module lpl_back #(
  parameter int LOOKAHEAD_DEPTH = lpl_pkg::DEF_DEPTH
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [7:0]     lookahead_frames,
  input  wire logic [18:0]    release_step,
  input  wire logic           q_valid,
  output logic                q_ready,
  input  wire lpl_pkg::item_t q_item,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [19:0]         out_left,
  output logic [19:0]         out_right,
  output logic [18:0]         gain_applied
);
  localparam int AW = $clog2(LOOKAHEAD_DEPTH);
  localparam int PW = AW + 1;
  localparam int CW = AW + 9;
  localparam int DQW = lpl_pkg::GAIN_W + AW;
  localparam int PW_MUL = lpl_pkg::SAMPLE_W + lpl_pkg::GAIN_W;

  typedef enum logic [2:0] {
    B_IDLE, B_POP, B_PUSH, B_EMIT_RD, B_EMIT_CALC, B_EMIT_MUL, B_EMIT_OUT
  } bstate_t;

  bstate_t              state;
  lpl_pkg::item_t       item;
  logic [AW-1:0]        wp;
  logic [PW-1:0]        pending;
  logic [PW-1:0]        dq_head, dq_tail;
  logic [18:0]          cur_gain;
  logic [47:0]          frame;
  logic [PW_MUL-1:0]    prod_l, prod_r;

  // memories: delay line and a monotonic min-deque of (needed gain, frame slot)
  logic                 fr_we, dq_we;
  logic [AW-1:0]        fr_raddr, dq_raddr, dq_waddr;
  logic [47:0]          fr_rdata;
  logic [DQW-1:0]       dq_rdata, dq_wdata;

  logic [AW-1:0]        oldest;
  logic [CW-1:0]        la_eff;
  logic [18:0]          tgt;
  logic [AW-1:0]        tgt_slot;
  logic [19:0]          rise;
  logic [23:0]          mag_l, mag_r;
  logic [19:0]          res_l, res_r;

  lpl_ram #(.WIDTH(48), .DEPTH(LOOKAHEAD_DEPTH)) u_frames (
    .clk(clk), .we(fr_we), .waddr(wp), .wdata({item.right, item.left}),
    .raddr(fr_raddr), .rdata(fr_rdata)
  );

  lpl_ram #(.WIDTH(DQW), .DEPTH(LOOKAHEAD_DEPTH)) u_mindq (
    .clk(clk), .we(dq_we), .waddr(dq_waddr), .wdata(dq_wdata),
    .raddr(dq_raddr), .rdata(dq_rdata)
  );

  // effective lookahead, clamped to 1 .. depth-1
  always_comb begin
    la_eff = CW'(lookahead_frames);
    if (la_eff == '0) la_eff = CW'(1);
    if (la_eff > CW'(LOOKAHEAD_DEPTH - 1)) la_eff = CW'(LOOKAHEAD_DEPTH - 1);
  end

  assign oldest   = wp - pending[AW-1:0];
  assign tgt      = dq_rdata[DQW-1:AW];
  assign tgt_slot = dq_rdata[AW-1:0];
  assign rise     = {1'b0, cur_gain} + {1'b0, release_step};
  assign q_ready  = (state == B_IDLE);

  // memory port control
  always_comb begin
    fr_we    = (state == B_PUSH);
    dq_we    = (state == B_PUSH);
    dq_waddr = dq_tail[AW-1:0];
    dq_wdata = {item.needed, wp};
    fr_raddr = oldest;
    dq_raddr = dq_head[AW-1:0];
    if (state == B_IDLE) begin
      dq_raddr = dq_tail[AW-1:0] - 1'b1;
    end else if (state == B_POP) begin
      dq_raddr = dq_tail[AW-1:0] - AW'(2);
    end
  end

  // round to nearest, clamp to unity, restore sign
  always_comb begin
    logic [PW_MUL-1:0] sl, sr;
    logic [PW_MUL-lpl_pkg::FRAC_BITS-1:0] ml, mr;
    sl = prod_l + PW_MUL'(1 << (lpl_pkg::FRAC_BITS - 1));
    sr = prod_r + PW_MUL'(1 << (lpl_pkg::FRAC_BITS - 1));
    ml = sl[PW_MUL-1:lpl_pkg::FRAC_BITS];
    mr = sr[PW_MUL-1:lpl_pkg::FRAC_BITS];
    if (ml > (PW_MUL-lpl_pkg::FRAC_BITS)'(lpl_pkg::UNITY)) begin
      ml = (PW_MUL-lpl_pkg::FRAC_BITS)'(lpl_pkg::UNITY);
    end
    if (mr > (PW_MUL-lpl_pkg::FRAC_BITS)'(lpl_pkg::UNITY)) begin
      mr = (PW_MUL-lpl_pkg::FRAC_BITS)'(lpl_pkg::UNITY);
    end
    res_l = frame[23] ? 20'(-ml[19:0]) : ml[19:0];
    res_r = frame[47] ? 20'(-mr[19:0]) : mr[19:0];
    mag_l = frame[23] ? 24'(-frame[23:0]) : frame[23:0];
    mag_r = frame[47] ? 24'(-frame[47:24]) : frame[47:24];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      wp        <= '0;
      pending   <= '0;
      dq_head   <= '0;
      dq_tail   <= '0;
      cur_gain  <= lpl_pkg::UNITY;
      out_valid <= 1'b0;
    end else begin
      // output beat taken; a new one loaded in B_EMIT_OUT takes its place
      if (out_valid && out_ready && state != B_EMIT_OUT) out_valid <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (q_valid) begin
            item <= q_item;
            if (q_item.kind == lpl_pkg::KIND_DRAIN) begin
              if (pending != '0) state <= B_EMIT_RD;
            end else if (dq_tail != dq_head) begin
              state <= B_POP;
            end else begin
              state <= B_PUSH;
            end
          end
        end
        // drop entries from the back that are no smaller than the new one
        B_POP: begin
          if (tgt >= item.needed) begin
            dq_tail <= dq_tail - 1'b1;
            if (dq_tail - 1'b1 == dq_head) state <= B_PUSH;
          end else begin
            state <= B_PUSH;
          end
        end
        B_PUSH: begin
          dq_tail <= dq_tail + 1'b1;
          wp      <= wp + 1'b1;
          pending <= pending + 1'b1;
          if (CW'(pending) + CW'(1) > la_eff) state <= B_EMIT_RD;
          else state <= B_IDLE;
        end
        B_EMIT_RD: state <= B_EMIT_CALC;
        B_EMIT_CALC: begin
          if (tgt < cur_gain) cur_gain <= tgt;
          else if (rise > 20'(lpl_pkg::UNITY)) cur_gain <= lpl_pkg::UNITY;
          else cur_gain <= rise[18:0];
          if (tgt_slot == oldest) dq_head <= dq_head + 1'b1;
          pending <= pending - 1'b1;
          frame   <= fr_rdata;
          state   <= B_EMIT_MUL;
        end
        B_EMIT_MUL: begin
          prod_l <= PW_MUL'(mag_l) * PW_MUL'(cur_gain);
          prod_r <= PW_MUL'(mag_r) * PW_MUL'(cur_gain);
          state  <= B_EMIT_OUT;
        end
        B_EMIT_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            out_left     <= res_l;
            out_right    <= res_r;
            gain_applied <= cur_gain;
            state        <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: sv/lookahead_peak_limiter_unit.sv
// Lookahead peak limiter.
// Input stream (s_*): one beat per request. s_tuser is the request kind
// (0 = new frame, 1 = drain one pending frame); s_tdata holds the left and
// right Q5.18 samples. Output stream (m_*): one beat per released frame with
// the limited samples and the gain applied.
// A frame is released once lookahead_frames (clamped to 1..depth-1) newer
// frames have arrived, or by a drain; a drain with none pending gives no beat.
// Per item: the front accepts a request, runs the restoring divider when a
// frame's peak exceeds the ceiling, and hands the item over; the back takes
// it, drops min-queue entries from the back that are no smaller than the new
// one, stores the frame, and when a frame is released reads it out, updates
// the gain, multiplies and registers the output beat. Neither side takes a
// new request before it is through with the last one.
// A two-entry queue between front and back and an output register let each
// side stall on its own; when m_tready is low the back holds its result and
// the front keeps accepting until the queue fills.
// Reset (rst, synchronous) restores register defaults, unity gain and an
// empty delay line; no clearing pass is needed. Registers are to be written
// over APB only while idle; the block does not enforce this.
`default_nettype none
module lookahead_peak_limiter_unit #(
  parameter int LOOKAHEAD_DEPTH = lpl_pkg::DEF_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [47:0] s_tdata,   // sample_left[23:0], sample_right[47:24]
  input  wire logic [0:0]  s_tuser,   // req_type[0]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // out_left[19:0], out_right[39:20], gain_applied[58:40]
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [18:0] ceiling, release_step;
  logic [7:0]  lookahead_frames;
  logic [1:0]  channels_in_use;
  logic [19:0] out_left, out_right;
  logic [18:0] gain_applied;

  lpl_pkg::item_t fq_item, bq_item;
  logic           fq_valid, fq_ready, bq_valid, bq_ready;

  // register file
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling          <= lpl_pkg::CEILING_RST;
      lookahead_frames <= lpl_pkg::LOOKAHEAD_RST;
      release_step     <= lpl_pkg::RELEASE_RST;
      channels_in_use  <= lpl_pkg::CHANNELS_RST;
    end else if (psel && penable && pwrite && paddr[1:0] == 2'd0) begin
      unique case (paddr[3:2])
        lpl_pkg::REG_CEILING:   ceiling          <= pwdata[18:0];
        lpl_pkg::REG_LOOKAHEAD: lookahead_frames <= pwdata[7:0];
        lpl_pkg::REG_RELEASE:   release_step     <= pwdata[18:0];
        lpl_pkg::REG_CHANNELS:  channels_in_use  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      lpl_pkg::REG_CEILING:   prdata = 32'(ceiling);
      lpl_pkg::REG_LOOKAHEAD: prdata = 32'(lookahead_frames);
      lpl_pkg::REG_RELEASE:   prdata = 32'(release_step);
      lpl_pkg::REG_CHANNELS:  prdata = 32'(channels_in_use);
      default:                prdata = 32'd0;
    endcase
  end

  lpl_front u_front (
    .clk(clk), .rst(rst), .ceiling(ceiling), .channels_in_use(channels_in_use),
    .in_valid(s_tvalid), .in_ready(s_tready), .in_kind(s_tuser[0]),
    .in_data(s_tdata), .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item)
  );

  lpl_queue u_queue (
    .clk(clk), .rst(rst), .wr_valid(fq_valid), .wr_ready(fq_ready),
    .wr_item(fq_item), .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_item(bq_item)
  );

  lpl_back #(.LOOKAHEAD_DEPTH(LOOKAHEAD_DEPTH)) u_back (
    .clk(clk), .rst(rst), .lookahead_frames(lookahead_frames),
    .release_step(release_step), .q_valid(bq_valid), .q_ready(bq_ready),
    .q_item(bq_item), .out_valid(m_tvalid), .out_ready(m_tready),
    .out_left(out_left), .out_right(out_right), .gain_applied(gain_applied)
  );

  assign m_tdata = {5'd0, gain_applied, out_right, out_left};
endmodule
`default_nettype wire
